FILE: rtl/m3i_pkg.sv
`timescale 1ns / 1ps
// m3i_pkg: beat types, sideband struct and cofactor operand tables for the 3x3 inverse.
// No dependencies; every other file of the block refers to it by scoped names.
package m3i_pkg;

  localparam int unsigned IoBits  = 32;
  localparam int unsigned NumElem = 9;
  localparam int unsigned NumRow  = 3;

  typedef logic signed [IoBits-1:0] word_t;

  typedef struct packed {
    word_t col0_row0;
    word_t col0_row1;
    word_t col0_row2;
    word_t col1_row0;
    word_t col1_row1;
    word_t col1_row2;
    word_t col2_row0;
    word_t col2_row1;
    word_t col2_row2;
  } in_t;

  typedef struct packed {
    word_t inv_col0_row0;
    word_t inv_col0_row1;
    word_t inv_col0_row2;
    word_t inv_col1_row0;
    word_t inv_col1_row1;
    word_t inv_col1_row2;
    word_t inv_col2_row0;
    word_t inv_col2_row1;
    word_t inv_col2_row2;
    word_t det_value;
    logic  singular;
    logic  saturated;
  } out_t;

  // Per-matrix status that rides along the quotient pipeline.
  typedef struct packed {
    logic [NumElem-1:0] neg;
    logic [NumElem-1:0] ovf;
    logic               sing;
    logic [IoBits-1:0]  det_word;
    logic               det_clip;
  } side_t;

  // Cofactor k = e[CofA[k]] * e[CofB[k]] - e[CofC[k]] * e[CofD[k]], elements column-major.
  localparam int unsigned CofA [NumElem] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned CofB [NumElem] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned CofC [NumElem] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned CofD [NumElem] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

FILE: rtl/m3i_cofac.sv
`timescale 1ns / 1ps
// m3i_cofac: sign-extends the nine elements and forms the nine exact 2x2 cofactors.
// Two register stages (products, then differences). Depends on m3i_pkg.
module m3i_cofac #(
  parameter int unsigned W = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic [m3i_pkg::IoBits-1:0]   elem_i [m3i_pkg::NumElem],
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic signed [W-1:0]          col0_o [m3i_pkg::NumRow],
  output logic signed [2*W:0]          cof_o  [m3i_pkg::NumElem]
);
  localparam int unsigned PW = 2 * W;
  localparam int unsigned CW = 2 * W + 1;
  localparam int unsigned NE = m3i_pkg::NumElem;
  localparam int unsigned NR = m3i_pkg::NumRow;

  logic signed [W-1:0]  ex      [NE];
  logic signed [PW-1:0] pa_d    [NE];
  logic signed [PW-1:0] pb_d    [NE];
  logic signed [PW-1:0] pa_q    [NE];
  logic signed [PW-1:0] pb_q    [NE];
  logic signed [W-1:0]  s1_col_q [NR];
  logic signed [W-1:0]  s2_col_q [NR];
  logic signed [CW-1:0] cof_d   [NE];
  logic signed [CW-1:0] cof_q   [NE];
  logic [1:0]           v_q;
  logic [2:0]           go;

  always_comb begin
    go[2] = !stall_i;
    go[1] = !v_q[1] || go[2];
    go[0] = !v_q[0] || go[1];
  end

  assign stall_o = !go[0];
  assign valid_o = v_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (go[0]) v_q[0] <= valid_i;
      if (go[1]) v_q[1] <= v_q[0];
    end
  end

  always_comb begin
    for (int k = 0; k < NE; k++) begin
      ex[k] = $signed(elem_i[k][W-1:0]);
    end
    for (int k = 0; k < NE; k++) begin
      pa_d[k] = PW'(ex[m3i_pkg::CofA[k]]) * PW'(ex[m3i_pkg::CofB[k]]);
      pb_d[k] = PW'(ex[m3i_pkg::CofC[k]]) * PW'(ex[m3i_pkg::CofD[k]]);
    end
    for (int k = 0; k < NE; k++) begin
      cof_d[k] = CW'(pa_q[k]) - CW'(pb_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      for (int r = 0; r < NR; r++) s1_col_q[r] <= ex[r];
    end
    if (go[1]) begin
      cof_q    <= cof_d;
      s2_col_q <= s1_col_q;
    end
  end

  assign col0_o = s2_col_q;
  assign cof_o  = cof_q;

endmodule

FILE: rtl/m3i_det.sv
`timescale 1ns / 1ps
// m3i_det: determinant by expansion down column 0, exact, over three register stages.
// Each wide product is split into two 32-bit-class partial products. Depends on m3i_pkg.
module m3i_det #(
  parameter int unsigned W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic signed [W-1:0]  col0_i [m3i_pkg::NumRow],
  input  logic signed [2*W:0]  cof_i  [m3i_pkg::NumElem],
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic signed [2*W:0]  cof_o  [m3i_pkg::NumElem],
  output logic signed [3*W+2:0] det_o
);
  localparam int unsigned CW = 2 * W + 1;
  localparam int unsigned LW = 2 * W + 1;
  localparam int unsigned TW = 3 * W + 1;
  localparam int unsigned DW = 3 * W + 3;
  localparam int unsigned NE = m3i_pkg::NumElem;
  localparam int unsigned NR = m3i_pkg::NumRow;

  logic signed [CW-1:0] c_sel  [NR];
  logic signed [LW-1:0] pl_d   [NR];
  logic signed [LW-1:0] ph_d   [NR];
  logic signed [LW-1:0] pl_q   [NR];
  logic signed [LW-1:0] ph_q   [NR];
  logic signed [TW-1:0] term_d [NR];
  logic signed [TW-1:0] term_q [NR];
  logic signed [DW-1:0] det_d;
  logic signed [DW-1:0] det_q;
  logic signed [CW-1:0] cof1_q [NE];
  logic signed [CW-1:0] cof2_q [NE];
  logic signed [CW-1:0] cof3_q [NE];
  logic [2:0]           v_q;
  logic [3:0]           go;

  always_comb begin
    go[3] = !stall_i;
    for (int s = 2; s >= 0; s--) go[s] = !v_q[s] || go[s+1];
  end

  assign stall_o = !go[0];
  assign valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (go[0]) v_q[0] <= valid_i;
      if (go[1]) v_q[1] <= v_q[0];
      if (go[2]) v_q[2] <= v_q[1];
    end
  end

  always_comb begin
    for (int r = 0; r < NR; r++) begin
      c_sel[r] = cof_i[3*r];
      // low half unsigned, high half signed
      pl_d[r] = LW'(col0_i[r]) * LW'($signed({1'b0, c_sel[r][W-1:0]}));
      ph_d[r] = LW'(col0_i[r]) * LW'($signed(c_sel[r][CW-1:W]));
    end
    for (int r = 0; r < NR; r++) begin
      term_d[r] = (TW'(ph_q[r]) <<< W) + TW'(pl_q[r]);
    end
    det_d = DW'(term_q[0]) + DW'(term_q[1]) + DW'(term_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      pl_q   <= pl_d;
      ph_q   <= ph_d;
      cof1_q <= cof_i;
    end
    if (go[1]) begin
      term_q <= term_d;
      cof2_q <= cof1_q;
    end
    if (go[2]) begin
      det_q  <= det_d;
      cof3_q <= cof2_q;
    end
  end

  assign cof_o = cof3_q;
  assign det_o = det_q;

endmodule

FILE: rtl/m3i_prep.sv
`timescale 1ns / 1ps
// m3i_prep: magnitudes, rounded dividends, overflow pre-check and the saturated determinant.
// Three register stages between m3i_det and m3i_div. Depends on m3i_pkg.
module m3i_prep #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [2*W:0]           cof_i [m3i_pkg::NumElem],
  input  logic signed [3*W+2:0]         det_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [3*W+2*F+3:0]            num_o [m3i_pkg::NumElem],
  output logic [3*W+3:0]                dd_o,
  output m3i_pkg::side_t                side_o
);
  localparam int unsigned CW = 2 * W + 1;
  localparam int unsigned DW = 3 * W + 3;
  localparam int unsigned VW = DW + 1;
  localparam int unsigned NW = 3 * W + 2 * F + 4;
  localparam int unsigned RW = NW + W;
  localparam int unsigned NE = m3i_pkg::NumElem;
  localparam int unsigned OB = m3i_pkg::IoBits + 1;
  localparam logic [VW-1:0] Half    = VW'(1) << (2 * F - 1);
  localparam logic [VW-1:0] HalfRng = VW'(1) << (W - 1);

  // stage 4
  logic [DW-1:0]  det_u;
  logic [CW-1:0]  c_u    [NE];
  logic [DW-1:0]  dmag_d;
  logic [CW-1:0]  cmag_d [NE];
  logic [NE-1:0]  neg_d;
  logic [DW-1:0]  dmag_q;
  logic [CW-1:0]  cmag_q [NE];
  logic [NE-1:0]  s4_neg_q;
  logic           s4_dneg_q;
  logic           s4_sing_q;
  // stage 5
  logic [NW-1:0]  num_d  [NE];
  logic [RW-1:0]  thrp_d;
  logic [RW-1:0]  thrn_d;
  logic [VW-1:0]  dv_d;
  logic [NW-1:0]  num5_q [NE];
  logic [RW-1:0]  thrp_q;
  logic [RW-1:0]  thrn_q;
  logic [VW-1:0]  dv_q;
  logic [DW:0]    dd5_q;
  logic [NE-1:0]  s5_neg_q;
  logic           s5_dneg_q;
  logic           s5_sing_q;
  // stage 6
  logic [VW-1:0]  dlim;
  logic [VW-1:0]  dm;
  logic [OB-1:0]  dword;
  logic [NE-1:0]  ovf_d;
  logic           dclip_d;
  logic [NW-1:0]  num6_q [NE];
  logic [DW:0]    dd6_q;
  m3i_pkg::side_t side_q;
  logic [2:0]     v_q;
  logic [3:0]     go;

  always_comb begin
    go[3] = !stall_i;
    for (int s = 2; s >= 0; s--) go[s] = !v_q[s] || go[s+1];
  end

  assign stall_o = !go[0];
  assign valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (go[0]) v_q[0] <= valid_i;
      if (go[1]) v_q[1] <= v_q[0];
      if (go[2]) v_q[2] <= v_q[1];
    end
  end

  always_comb begin
    det_u  = det_i;
    dmag_d = det_u[DW-1] ? (DW'(0) - det_u) : det_u;
    for (int k = 0; k < NE; k++) begin
      c_u[k]    = cof_i[k];
      cmag_d[k] = c_u[k][CW-1] ? (CW'(0) - c_u[k]) : c_u[k];
      neg_d[k]  = c_u[k][CW-1] ^ det_u[DW-1];
    end

    // dividend 2*|c|*2^(2F) + |det| against divisor 2*|det| gives the rounded quotient
    for (int k = 0; k < NE; k++) begin
      num_d[k] = (NW'(cmag_q[k]) << (2 * F + 1)) + NW'(dmag_q);
    end
    thrp_d = RW'(dmag_q) << W;
    thrn_d = (RW'(dmag_q) << W) + (RW'(dmag_q) << 1);
    dv_d   = (VW'(dmag_q) + Half) >> (2 * F);

    for (int k = 0; k < NE; k++) begin
      ovf_d[k] = RW'(num5_q[k]) >= (s5_neg_q[k] ? thrn_q : thrp_q);
    end
    dlim    = s5_dneg_q ? HalfRng : (HalfRng - VW'(1));
    dclip_d = dv_q > dlim;
    dm      = dclip_d ? dlim : dv_q;
    dword   = s5_dneg_q ? (OB'(0) - OB'(dm)) : OB'(dm);
  end

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      dmag_q    <= dmag_d;
      cmag_q    <= cmag_d;
      s4_neg_q  <= neg_d;
      s4_dneg_q <= det_u[DW-1];
      s4_sing_q <= (det_u == '0);
    end
    if (go[1]) begin
      num5_q    <= num_d;
      thrp_q    <= thrp_d;
      thrn_q    <= thrn_d;
      dv_q      <= dv_d;
      dd5_q     <= {dmag_q, 1'b0};
      s5_neg_q  <= s4_neg_q;
      s5_dneg_q <= s4_dneg_q;
      s5_sing_q <= s4_sing_q;
    end
    if (go[2]) begin
      num6_q          <= num5_q;
      dd6_q           <= dd5_q;
      side_q.neg      <= s5_neg_q;
      side_q.ovf      <= ovf_d;
      side_q.sing     <= s5_sing_q;
      side_q.det_word <= dword[OB-2:0];
      side_q.det_clip <= dclip_d;
    end
  end

  assign num_o  = num6_q;
  assign dd_o   = dd6_q;
  assign side_o = side_q;

endmodule

FILE: rtl/m3i_div.sv
`timescale 1ns / 1ps
// m3i_div: nine restoring dividers in lockstep, one quotient bit per register stage.
// WORD_BITS stages, most significant bit first. Depends on m3i_pkg.
module m3i_div #(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic [3*W+2*F+3:0]   num_i  [m3i_pkg::NumElem],
  input  logic [3*W+3:0]       dd_i,
  input  m3i_pkg::side_t       side_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output logic [W-1:0]         quot_o [m3i_pkg::NumElem],
  output m3i_pkg::side_t       side_o
);
  localparam int unsigned NW  = 3 * W + 2 * F + 4;
  localparam int unsigned RW  = NW + W;
  localparam int unsigned DDW = 3 * W + 4;
  localparam int unsigned NE  = m3i_pkg::NumElem;

  logic [RW-1:0]  rem_w  [W+1][NE];
  logic [W-1:0]   quot_w [W+1][NE];
  logic [DDW-1:0] dd_w   [W+1];
  m3i_pkg::side_t side_w [W+1];
  logic [W:0]     vld_w;
  logic [W:0]     go;

  always_comb begin
    go[W] = !stall_i;
    for (int s = W - 1; s >= 0; s--) go[s] = !vld_w[s+1] || go[s+1];
  end

  assign stall_o  = !go[0];
  assign vld_w[0] = valid_i;
  assign dd_w[0]  = dd_i;
  assign side_w[0] = side_i;

  for (genvar k = 0; k < NE; k++) begin : g_in
    assign rem_w[0][k]  = RW'(num_i[k]);
    assign quot_w[0][k] = '0;
  end

  for (genvar s = 0; s < W; s++) begin : g_stage
    localparam int unsigned Bit = W - 1 - s;

    logic [RW-1:0]  thr;
    logic [RW-1:0]  rem_d  [NE];
    logic [W-1:0]   quot_d [NE];
    logic [RW-1:0]  rem_q  [NE];
    logic [W-1:0]   quot_q [NE];
    logic [DDW-1:0] dd_q;
    m3i_pkg::side_t side_q;
    logic           v_q;

    always_comb begin
      thr = RW'(dd_w[s]) << Bit;
      for (int k = 0; k < NE; k++) begin
        if (rem_w[s][k] >= thr) begin
          rem_d[k]  = rem_w[s][k] - thr;
          quot_d[k] = quot_w[s][k] | (W'(1) << Bit);
        end else begin
          rem_d[k]  = rem_w[s][k];
          quot_d[k] = quot_w[s][k];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (go[s]) begin
        v_q <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (go[s]) begin
        rem_q  <= rem_d;
        quot_q <= quot_d;
        dd_q   <= dd_w[s];
        side_q <= side_w[s];
      end
    end

    assign vld_w[s+1]  = v_q;
    assign dd_w[s+1]   = dd_q;
    assign side_w[s+1] = side_q;
    for (genvar k = 0; k < NE; k++) begin : g_lane
      assign rem_w[s+1][k]  = rem_q[k];
      assign quot_w[s+1][k] = quot_q[k];
    end
  end

  assign valid_o = vld_w[W];
  assign side_o  = side_w[W];
  assign quot_o  = quot_w[W];

endmodule

FILE: rtl/matrix3x3_inverse.sv
`timescale 1ns / 1ps
// matrix3x3_inverse: top level of the 3x3 fixed-point inverse pipeline and its output register.
// Depends on m3i_pkg, m3i_cofac, m3i_det, m3i_prep and m3i_div.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries one matrix per beat (in_data_i, nine
//   signed elements, column-major). Output channel out_valid_o / out_stall_i carries the
//   inverse, the determinant and the singular and saturated flags (out_data_o).
//   A beat moves at a clock edge where valid is high and stall is low.
//   Throughput: one matrix per cycle, sustained while out_stall_i stays low.
//   From input beat to output valid a matrix passes through two cofactor stages, three
//   determinant stages, three preparation stages, one stage per quotient bit in the
//   divider pipeline, and the output register.
//   Every pipeline stage holds its beat while the stage after it is full and stalled, so
//   bubbles are squeezed out and a stall on the output loses and repeats nothing;
//   in_stall_o rises only once every stage is occupied.
//   A zero determinant gives singular set, all-zero inverse and determinant.
//   Reset (rst_ni low, asynchronous) empties the pipeline; no output beat follows until
//   new input beats arrive.
module matrix3x3_inverse #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  m3i_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output m3i_pkg::out_t out_data_o
);
  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned NE  = m3i_pkg::NumElem;
  localparam int unsigned NR  = m3i_pkg::NumRow;
  localparam int unsigned IOB = m3i_pkg::IoBits;
  localparam int unsigned OB  = IOB + 1;
  localparam logic [W-1:0] HalfRng = W'(1) << (W - 1);

  logic [IOB-1:0]        elem [NE];

  logic                  cf_valid;
  logic                  cf_stall;
  logic signed [W-1:0]   cf_col0 [NR];
  logic signed [2*W:0]   cf_cof  [NE];

  logic                  dt_valid;
  logic                  dt_stall;
  logic signed [2*W:0]   dt_cof  [NE];
  logic signed [3*W+2:0] dt_det;

  logic                  pp_valid;
  logic                  pp_stall;
  logic [3*W+2*F+3:0]    pp_num  [NE];
  logic [3*W+3:0]        pp_dd;
  m3i_pkg::side_t        pp_side;

  logic                  dv_valid;
  logic                  dv_stall;
  logic [W-1:0]          dv_quot [NE];
  m3i_pkg::side_t        dv_side;

  logic [W-1:0]          lim  [NE];
  logic [W-1:0]          mag  [NE];
  logic [OB-1:0]         sval [NE];
  logic [IOB-1:0]        inv  [NE];
  logic                  sat;
  logic                  go_out;
  logic                  out_v_q;
  m3i_pkg::out_t         out_d;
  m3i_pkg::out_t         out_q;

  assign elem[0] = in_data_i.col0_row0;
  assign elem[1] = in_data_i.col0_row1;
  assign elem[2] = in_data_i.col0_row2;
  assign elem[3] = in_data_i.col1_row0;
  assign elem[4] = in_data_i.col1_row1;
  assign elem[5] = in_data_i.col1_row2;
  assign elem[6] = in_data_i.col2_row0;
  assign elem[7] = in_data_i.col2_row1;
  assign elem[8] = in_data_i.col2_row2;

  m3i_cofac #(.W(W)) u_cofac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .elem_i  (elem),
    .valid_o (cf_valid),
    .stall_i (cf_stall),
    .col0_o  (cf_col0),
    .cof_o   (cf_cof)
  );

  m3i_det #(.W(W)) u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cf_valid),
    .stall_o (cf_stall),
    .col0_i  (cf_col0),
    .cof_i   (cf_cof),
    .valid_o (dt_valid),
    .stall_i (dt_stall),
    .cof_o   (dt_cof),
    .det_o   (dt_det)
  );

  m3i_prep #(.W(W), .F(F)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dt_valid),
    .stall_o (dt_stall),
    .cof_i   (dt_cof),
    .det_i   (dt_det),
    .valid_o (pp_valid),
    .stall_i (pp_stall),
    .num_o   (pp_num),
    .dd_o    (pp_dd),
    .side_o  (pp_side)
  );

  m3i_div #(.W(W), .F(F)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pp_valid),
    .stall_o (pp_stall),
    .num_i   (pp_num),
    .dd_i    (pp_dd),
    .side_i  (pp_side),
    .valid_o (dv_valid),
    .stall_i (dv_stall),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // Output register: clip, apply sign, zero the inverse, determinant and saturated flag for a singular matrix.
  always_comb begin
    sat = dv_side.det_clip;
    for (int k = 0; k < NE; k++) begin
      lim[k]  = dv_side.neg[k] ? HalfRng : (HalfRng - W'(1));
      mag[k]  = dv_side.ovf[k] ? lim[k] : dv_quot[k];
      sval[k] = dv_side.neg[k] ? (OB'(0) - OB'(mag[k])) : OB'(mag[k]);
      inv[k]  = dv_side.sing ? '0 : sval[k][IOB-1:0];
      sat     = sat | dv_side.ovf[k];
    end
    out_d.inv_col0_row0 = inv[0];
    out_d.inv_col0_row1 = inv[1];
    out_d.inv_col0_row2 = inv[2];
    out_d.inv_col1_row0 = inv[3];
    out_d.inv_col1_row1 = inv[4];
    out_d.inv_col1_row2 = inv[5];
    out_d.inv_col2_row0 = inv[6];
    out_d.inv_col2_row1 = inv[7];
    out_d.inv_col2_row2 = inv[8];
    out_d.det_value     = dv_side.sing ? '0 : dv_side.det_word;
    out_d.singular      = dv_side.sing;
    out_d.saturated     = !dv_side.sing && sat;
  end

  assign go_out   = !out_v_q || !out_stall_i;
  assign dv_stall = !go_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (go_out) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_out) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/m3i_check.sv
`timescale 1ns / 1ps
// m3i_check: port-level checks for matrix3x3_inverse, attached by the bind below.
// Depends on m3i_pkg and the top level's ports.
module m3i_check (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input m3i_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input m3i_pkg::out_t out_data_o
);

  // An empty pipeline after reset: no output beat while reset is held.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // With the receiver taking every beat, the input side never stalls.
  a_no_stall_free: assert property (@(posedge clk_i) !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output flows freely");

  // A singular matrix reports a zero determinant, zero diagonal inverse elements and no saturation.
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.det_value == '0 && !out_data_o.saturated &&
      out_data_o.inv_col0_row0 == '0 && out_data_o.inv_col1_row1 == '0 &&
      out_data_o.inv_col2_row2 == '0)
    else $error("singular beat with nonzero payload");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

endmodule

bind matrix3x3_inverse m3i_check u_m3i_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: sim/matrix3x3_inverse_tb.sv
`timescale 1ns / 1ps
// matrix3x3_inverse_tb: drives random and directed 3x3 matrices into matrix3x3_inverse and
// checks every output beat against an in-bench fixed-point inverse predictor.
// Depends on m3i_pkg and the matrix3x3_inverse RTL.

class inverse_scoreboard;
  m3i_pkg::out_t pending_q[$];
  int unsigned   errors;

  function automatic logic signed [127:0] sx(m3i_pkg::word_t w);
    return {{96{w[31]}}, w};
  endfunction

  // Clip a magnitude to the 32-bit signed range and apply the sign.
  function automatic m3i_pkg::word_t clip_word(logic [127:0] mag, logic neg, ref logic clip);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > lim) begin
      mag  = lim;
      clip = 1'b1;
    end
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  function automatic m3i_pkg::out_t invert(m3i_pkg::in_t m);
    logic signed [127:0] e[9];
    logic signed [127:0] cf[9];
    logic signed [127:0] det;
    logic [127:0]        dmag, cmag, q;
    logic                dneg, clip;
    m3i_pkg::word_t      r[9];
    m3i_pkg::out_t       o;
    e[0] = sx(m.col0_row0); e[1] = sx(m.col0_row1); e[2] = sx(m.col0_row2);
    e[3] = sx(m.col1_row0); e[4] = sx(m.col1_row1); e[5] = sx(m.col1_row2);
    e[6] = sx(m.col2_row0); e[7] = sx(m.col2_row1); e[8] = sx(m.col2_row2);
    cf[0] = e[4]*e[8] - e[5]*e[7];
    cf[1] = e[2]*e[7] - e[1]*e[8];
    cf[2] = e[1]*e[5] - e[2]*e[4];
    cf[3] = e[5]*e[6] - e[3]*e[8];
    cf[4] = e[0]*e[8] - e[2]*e[6];
    cf[5] = e[2]*e[3] - e[0]*e[5];
    cf[6] = e[3]*e[7] - e[4]*e[6];
    cf[7] = e[1]*e[6] - e[0]*e[7];
    cf[8] = e[0]*e[4] - e[1]*e[3];
    // cofactors wrap to 64 bits before use
    for (int i = 0; i < 9; i++) cf[i] = {{64{cf[i][63]}}, cf[i][63:0]};
    det = e[0]*cf[0] + e[1]*cf[3] + e[2]*cf[6];
    o = '0;
    if (det == 0) begin
      o.singular = 1'b1;
      return o;
    end
    clip = 1'b0;
    dneg = det[127];
    dmag = dneg ? -det : det;
    for (int i = 0; i < 9; i++) begin
      cmag = cf[i][127] ? -cf[i] : cf[i];
      q    = ((cmag << 33) + dmag) / (dmag << 1);
      r[i] = clip_word(q, cf[i][127] != dneg, clip);
    end
    o.inv_col0_row0 = r[0]; o.inv_col0_row1 = r[1]; o.inv_col0_row2 = r[2];
    o.inv_col1_row0 = r[3]; o.inv_col1_row1 = r[4]; o.inv_col1_row2 = r[5];
    o.inv_col2_row0 = r[6]; o.inv_col2_row1 = r[7]; o.inv_col2_row2 = r[8];
    o.det_value = clip_word((dmag + (128'd1 << 31)) >> 32, dneg, clip);
    o.saturated = clip;
    return o;
  endfunction

  function void note_matrix(m3i_pkg::in_t m);
    pending_q.push_back(invert(m));
  endfunction

  function void check_result(m3i_pkg::out_t got);
    m3i_pkg::out_t want;
    if (pending_q.size() == 0) begin
      $error("output beat with no matrix outstanding");
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (got.inv_col0_row0 !== want.inv_col0_row0) cmp("inv_col0_row0", want.inv_col0_row0, got.inv_col0_row0);
    if (got.inv_col0_row1 !== want.inv_col0_row1) cmp("inv_col0_row1", want.inv_col0_row1, got.inv_col0_row1);
    if (got.inv_col0_row2 !== want.inv_col0_row2) cmp("inv_col0_row2", want.inv_col0_row2, got.inv_col0_row2);
    if (got.inv_col1_row0 !== want.inv_col1_row0) cmp("inv_col1_row0", want.inv_col1_row0, got.inv_col1_row0);
    if (got.inv_col1_row1 !== want.inv_col1_row1) cmp("inv_col1_row1", want.inv_col1_row1, got.inv_col1_row1);
    if (got.inv_col1_row2 !== want.inv_col1_row2) cmp("inv_col1_row2", want.inv_col1_row2, got.inv_col1_row2);
    if (got.inv_col2_row0 !== want.inv_col2_row0) cmp("inv_col2_row0", want.inv_col2_row0, got.inv_col2_row0);
    if (got.inv_col2_row1 !== want.inv_col2_row1) cmp("inv_col2_row1", want.inv_col2_row1, got.inv_col2_row1);
    if (got.inv_col2_row2 !== want.inv_col2_row2) cmp("inv_col2_row2", want.inv_col2_row2, got.inv_col2_row2);
    if (got.det_value !== want.det_value) cmp("det_value", want.det_value, got.det_value);
    if (got.singular !== want.singular) cmp("singular", want.singular, got.singular);
    if (got.saturated !== want.saturated) cmp("saturated", want.saturated, got.saturated);
  endfunction

  function void cmp(string field, logic [31:0] want, logic [31:0] got);
    $error("%s: expected %h, got %h", field, want, got);
    errors++;
  endfunction
endclass

module matrix3x3_inverse_tb;

  localparam int unsigned Latency   = 41;
  localparam int unsigned NumRandom = 455;
  localparam int unsigned LongHold  = 150;

  logic          clk, rst_n;
  logic          in_valid, in_stall, out_valid, out_stall;
  m3i_pkg::in_t  in_data;
  m3i_pkg::out_t out_data;

  inverse_scoreboard sb = new();
  bit   calm;        // no idling on either side
  bit   hold_req;    // receiver holds off for a long stretch
  bit   stim_done;

  matrix3x3_inverse u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("matrix3x3_inverse_tb: errors");
    $finish;
  end

  function automatic m3i_pkg::word_t rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh8000_0000 + $urandom_range(0, 3);
      2: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
      3: return $urandom_range(0, 1) ? $urandom_range(0, 255) : -$urandom_range(0, 255);
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic m3i_pkg::in_t diag(m3i_pkg::word_t a, m3i_pkg::word_t b,
                                       m3i_pkg::word_t c);
    m3i_pkg::in_t m;
    m = '0;
    m.col0_row0 = a;
    m.col1_row1 = b;
    m.col2_row2 = c;
    return m;
  endfunction

  // Offer one beat and hold it until accepted; gaps before it when idling is on.
  task automatic send_matrix(m3i_pkg::in_t m);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (in_stall);
    sb.note_matrix(m);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver stall: random, or a long counted hold-off on request.
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 27);
        @(posedge clk);
      end
    end
  end

  initial begin
    m3i_pkg::in_t m;
    in_valid  = 1'b0;
    in_data   = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    stim_done = 1'b0;
    rst_n     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, scaled, singular, extremes, tiny determinant, saturation.
    send_matrix(diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
    send_matrix(diag(32'sh0002_0000, -32'sh0004_0000, 32'sh0000_8000));
    send_matrix('0);
    send_matrix({9{32'sh0001_0000}});
    send_matrix({9{32'sh7FFF_FFFF}});
    send_matrix({9{32'sh8000_0000}});
    send_matrix(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_matrix(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_matrix(diag(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001));
    send_matrix(diag(32'sh0000_0100, 32'sh0000_0100, 32'sh0000_0100));
    send_matrix(diag(-32'sh0000_0001, 32'sh0001_0000, 32'sh0001_0000));
    send_matrix(diag(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001));
    send_matrix({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
                 32'h0, 32'h0, 32'hFFFF_FFFF});
    send_matrix({32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                 32'sh0000_0000, 32'sh0001_0000, 32'sh0004_0000,
                 32'sh0005_0000, 32'sh0006_0000, 32'sh0000_0000});
    send_matrix({32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                 32'h3333_3333, 32'hCCCC_CCCC, 32'h00FF_00FF, 32'hFF00_FF00, 32'h1234_5678});

    // Sender pauses until every result has come.
    drain();

    // Long receiver hold-off while the sender keeps offering beats.
    calm     = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 80; i++) begin
      for (int k = 0; k < 9; k++) m[k*32 +: 32] = rand_word();
      send_matrix(m);
    end
    while (hold_req) @(posedge clk);

    for (int i = 0; i < NumRandom; i++) begin
      calm = (i >= 100 && i < 160);
      for (int k = 0; k < 9; k++) m[k*32 +: 32] = rand_word();
      // make two columns linearly dependent now and then
      if ($urandom_range(0, 9) == 0) begin
        m.col2_row0 = m.col0_row0;
        m.col2_row1 = m.col0_row1;
        m.col2_row2 = m.col0_row2;
      end
      send_matrix(m);
    end
    calm = 1'b0;
    in_valid  <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("matrix3x3_inverse_tb: clean");
    end else begin
      $display("matrix3x3_inverse_tb: errors");
    end
    $finish;
  end
endmodule
